// File: design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the interval join checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted.
`define PKIJ_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("pkij assertion failed");

// Clocked assertion that is also checked during reset.
`define PKIJ_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("pkij assertion failed");

`endif

// File: design/pkij_pkg.sv
// ---------------------------------------------------------------------------
// Interval join package
// Widths, defaults and record types shared by the interval join modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pkij_pkg;

  localparam int unsigned TIME_W       = 63;
  localparam int unsigned KEY_W        = 6;
  localparam int unsigned TAG_W        = 32;
  localparam int unsigned NUM_KEYS_DEF = 64;

  // One stored row of a source and key
  typedef struct packed {
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] length;
    logic [TAG_W-1:0]  row_tag;
  } entry_t;

  // Candidate pair handed from front to back; ends are one bit wider
  typedef struct packed {
    logic [TIME_W-1:0] p_start;
    logic [TIME_W:0]   p_end;
    logic [TIME_W-1:0] o_start;
    logic [TIME_W:0]   o_end;
    logic [KEY_W-1:0]  key;
    logic [TAG_W-1:0]  first_tag;
    logic [TAG_W-1:0]  second_tag;
  } cand_t;

endpackage

// File: design/pkij_row_if.sv
// ---------------------------------------------------------------------------
// Row channel
// Valid/ready channel carrying one interval row per beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pkij_row_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [pkij_pkg::TIME_W-1:0] start_time;
  logic [pkij_pkg::TIME_W-1:0] length;
  logic [pkij_pkg::KEY_W-1:0]  cpu_key;
  logic [pkij_pkg::TAG_W-1:0]  row_tag;

  modport source (output valid, output func, output start_time, output length,
                  output cpu_key, output row_tag, input ready);
  modport sink   (input valid, input func, input start_time, input length,
                  input cpu_key, input row_tag, output ready);
endinterface

// File: design/pkij_span_if.sv
// ---------------------------------------------------------------------------
// Span channel
// Valid/ready channel carrying one joined intersection per beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pkij_span_if;
  logic                        valid;
  logic                        ready;
  logic [pkij_pkg::TIME_W-1:0] span_start;
  logic [pkij_pkg::TIME_W-1:0] span_length;
  logic [pkij_pkg::KEY_W-1:0]  span_cpu;
  logic [pkij_pkg::TAG_W-1:0]  first_tag;
  logic [pkij_pkg::TAG_W-1:0]  second_tag;

  modport source (output valid, output span_start, output span_length,
                  output span_cpu, output first_tag, output second_tag,
                  input ready);
  modport sink   (input valid, input span_start, input span_length,
                  input span_cpu, input first_tag, input second_tag,
                  output ready);
endinterface

// File: design/pkij_fifo.sv
// ---------------------------------------------------------------------------
// Candidate queue
// Two-entry queue decoupling the row front end from the join back end.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pkij_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  pkij_pkg::cand_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output pkij_pkg::cand_t pop_data_o
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = $clog2(Depth);

  pkij_pkg::cand_t slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]   count_q;
  logic            push, pop;

  assign push_ready_o = count_q != (PtrW+1)'(Depth);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// File: design/pkij_front.sv
// ---------------------------------------------------------------------------
// Row front end
// Accepts rows, swaps them into the per-source stores and forms join pairs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pkij_front #(
  parameter int unsigned NUM_KEYS = pkij_pkg::NUM_KEYS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  pkij_row_if.sink        row_i,
  output logic            cand_valid_o,
  input  logic            cand_ready_i,
  output pkij_pkg::cand_t cand_o
);

  localparam int unsigned KeyRange = 2 ** pkij_pkg::KEY_W;
  localparam int unsigned KeyDepth = (NUM_KEYS < KeyRange) ? NUM_KEYS : KeyRange;
  localparam int unsigned IdxW     = (KeyDepth > 1) ? $clog2(KeyDepth) : 1;

  pkij_pkg::entry_t mem0_q [KeyDepth];
  pkij_pkg::entry_t mem1_q [KeyDepth];
  logic [KeyDepth-1:0] vld0_q, vld1_q;

  logic                       in_range, accept, f1_ready, f2_ready;
  logic [IdxW-1:0]            idx;
  pkij_pkg::entry_t           wr_entry, rd0_q, rd1_q, own, oth;
  logic                       rv0_q, rv1_q, own_full, oth_full;
  logic                       f1_v_q, f1_src_q;
  logic [pkij_pkg::KEY_W-1:0] f1_key_q;
  logic                       f2_v_q;
  pkij_pkg::cand_t            f2_q, f2_d;

  assign in_range    = 32'(row_i.cpu_key) < NUM_KEYS;
  assign idx         = row_i.cpu_key[IdxW-1:0];
  assign f2_ready    = !f2_v_q || cand_ready_i;
  assign f1_ready    = !f1_v_q || f2_ready;
  assign row_i.ready = f1_ready;
  assign accept      = row_i.valid && f1_ready && in_range;

  assign wr_entry.start_time = row_i.start_time;
  assign wr_entry.length     = row_i.length;
  assign wr_entry.row_tag    = row_i.row_tag;

  // read-before-write: the read returns the row being swapped out
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd0_q <= mem0_q[idx];
      rd1_q <= mem1_q[idx];
      if (row_i.func) begin
        mem1_q[idx] <= wr_entry;
      end else begin
        mem0_q[idx] <= wr_entry;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= '0;
      vld1_q <= '0;
      rv0_q  <= 1'b0;
      rv1_q  <= 1'b0;
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
    end else begin
      if (accept) begin
        rv0_q <= vld0_q[idx];
        rv1_q <= vld1_q[idx];
        if (row_i.func) begin
          vld1_q[idx] <= 1'b1;
        end else begin
          vld0_q[idx] <= 1'b1;
        end
      end
      if (f1_ready) begin
        f1_v_q <= row_i.valid && in_range;
      end
      if (f2_ready) begin
        f2_v_q <= f1_v_q && own_full && oth_full;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f1_src_q <= row_i.func;
      f1_key_q <= row_i.cpu_key;
    end
    if (f2_ready) begin
      f2_q <= f2_d;
    end
  end

  always_comb begin
    own      = f1_src_q ? rd1_q : rd0_q;
    oth      = f1_src_q ? rd0_q : rd1_q;
    own_full = (f1_src_q ? rv1_q : rv0_q) && (own.start_time != '0);
    oth_full = (f1_src_q ? rv0_q : rv1_q) && (oth.start_time != '0);

    f2_d.p_start    = own.start_time;
    f2_d.p_end      = {1'b0, own.start_time} + {1'b0, own.length};
    f2_d.o_start    = oth.start_time;
    f2_d.o_end      = {1'b0, oth.start_time} + {1'b0, oth.length};
    f2_d.key        = f1_key_q;
    f2_d.first_tag  = f1_src_q ? oth.row_tag : own.row_tag;
    f2_d.second_tag = f1_src_q ? own.row_tag : oth.row_tag;
  end

  assign cand_valid_o = f2_v_q;
  assign cand_o       = f2_q;

endmodule

// File: design/pkij_back.sv
// ---------------------------------------------------------------------------
// Join back end
// Tests a pair for overlap and presents the intersection on the span channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pkij_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cand_valid_i,
  output logic            cand_ready_o,
  input  pkij_pkg::cand_t cand_i,
  pkij_span_if.source     span_o
);

  logic                        overlap, out_adv;
  logic [pkij_pkg::TIME_W-1:0] lo;
  logic [pkij_pkg::TIME_W:0]   hi, diff;

  logic                        b1_v_q;
  logic [pkij_pkg::TIME_W-1:0] b1_start_q;
  logic [pkij_pkg::TIME_W:0]   b1_end_q;
  logic [pkij_pkg::KEY_W-1:0]  b1_key_q;
  logic [pkij_pkg::TAG_W-1:0]  b1_first_q, b1_second_q;

  logic                        out_v_q;
  logic [pkij_pkg::TIME_W-1:0] out_start_q, out_length_q;
  logic [pkij_pkg::KEY_W-1:0]  out_cpu_q;
  logic [pkij_pkg::TAG_W-1:0]  out_first_q, out_second_q;

  // inclusive ends: touching intervals overlap
  assign overlap = (cand_i.p_end >= {1'b0, cand_i.o_start}) &&
                   (cand_i.o_end >= {1'b0, cand_i.p_start});
  assign lo      = (cand_i.p_start > cand_i.o_start) ? cand_i.p_start : cand_i.o_start;
  assign hi      = (cand_i.p_end < cand_i.o_end) ? cand_i.p_end : cand_i.o_end;
  assign diff    = b1_end_q - {1'b0, b1_start_q};

  assign out_adv      = !out_v_q || span_o.ready;
  assign cand_ready_o = !b1_v_q || out_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (cand_ready_o) begin
        b1_v_q <= cand_valid_i && overlap;
      end
      if (out_adv) begin
        out_v_q <= b1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cand_ready_o) begin
      b1_start_q  <= lo;
      b1_end_q    <= hi;
      b1_key_q    <= cand_i.key;
      b1_first_q  <= cand_i.first_tag;
      b1_second_q <= cand_i.second_tag;
    end
    if (out_adv && b1_v_q) begin
      out_start_q  <= b1_start_q;
      out_length_q <= diff[pkij_pkg::TIME_W-1:0];
      out_cpu_q    <= b1_key_q;
      out_first_q  <= b1_first_q;
      out_second_q <= b1_second_q;
    end
  end

  assign span_o.valid       = out_v_q;
  assign span_o.span_start  = out_start_q;
  assign span_o.span_length = out_length_q;
  assign span_o.span_cpu    = out_cpu_q;
  assign span_o.first_tag   = out_first_q;
  assign span_o.second_tag  = out_second_q;

endmodule

// File: design/per_key_interval_intersection_join.sv
// ---------------------------------------------------------------------------
// Per-key interval intersection join
// Keeps the latest row per source and cpu key and emits overlaps on swap-out.
// ---------------------------------------------------------------------------
// Throughput: one row per cycle unless stalled; the store is read and written
// once per beat. Front and back are parted by a two-entry queue and each
// holds its own stall.
// Reset: rst_ni clears the per-entry valid bits and all pipeline valids at once,
// so the stores read as empty straight out of reset with no clearing pass.
`timescale 1ns / 1ps

module per_key_interval_intersection_join #(
  parameter int unsigned NUM_KEYS = pkij_pkg::NUM_KEYS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pkij_row_if.sink    row_i,
  pkij_span_if.source span_o
);

  logic            fr_valid, fr_ready, bk_valid, bk_ready;
  pkij_pkg::cand_t fr_cand, bk_cand;

  pkij_front #(
    .NUM_KEYS (NUM_KEYS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .row_i        (row_i),
    .cand_valid_o (fr_valid),
    .cand_ready_i (fr_ready),
    .cand_o       (fr_cand)
  );

  pkij_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_data_i  (fr_cand),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_data_o   (bk_cand)
  );

  pkij_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cand_valid_i (bk_valid),
    .cand_ready_o (bk_ready),
    .cand_i       (bk_cand),
    .span_o       (span_o)
  );

endmodule

// File: design/pkij_checker.sv
// ---------------------------------------------------------------------------
// Interval join checker
// Port-level assertions on the span channel, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pkij_checker #(
  parameter int unsigned NUM_KEYS = pkij_pkg::NUM_KEYS_DEF
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        span_valid_i,
  input logic                        span_ready_i,
  input logic [pkij_pkg::TIME_W-1:0] span_start_i,
  input logic [pkij_pkg::TIME_W-1:0] span_length_i,
  input logic [pkij_pkg::KEY_W-1:0]  span_cpu_i,
  input logic [pkij_pkg::TAG_W-1:0]  first_tag_i,
  input logic [pkij_pkg::TAG_W-1:0]  second_tag_i
);

  `PKIJ_ASSERT(a_stall_hold, clk_i, rst_ni, span_valid_i && !span_ready_i |=> span_valid_i && $stable(span_start_i) && $stable(span_length_i) && $stable(span_cpu_i) && $stable(first_tag_i) && $stable(second_tag_i))
  `PKIJ_ASSERT(a_start_nonzero, clk_i, rst_ni, span_valid_i |-> span_start_i != '0)
  `PKIJ_ASSERT(a_cpu_in_range, clk_i, rst_ni, span_valid_i |-> 32'(span_cpu_i) < NUM_KEYS)
  `PKIJ_ASSERT_ALWAYS(a_quiet_in_reset, clk_i, !rst_ni |-> !span_valid_i)

endmodule

bind per_key_interval_intersection_join pkij_checker #(
  .NUM_KEYS (NUM_KEYS)
) u_pkij_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .span_valid_i  (span_o.valid),
  .span_ready_i  (span_o.ready),
  .span_start_i  (span_o.span_start),
  .span_length_i (span_o.span_length),
  .span_cpu_i    (span_o.span_cpu),
  .first_tag_i   (span_o.first_tag),
  .second_tag_i  (span_o.second_tag)
);
